// ===== design/scte_pkg.sv =====
// Shared types, register codes and reset values for the swept circle contact time block.
package scte_pkg;

  localparam logic [15:0] RadiusScaleRst = 16'd4096;
  localparam logic [31:0] StillThrRst    = 32'd7;

  typedef enum logic [0:0] {
    CfgRadiusScale = 1'b0,
    CfgStillThr    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OcMoving = 2'd0,
    OcStill  = 2'd1,
    OcNoRoot = 2'd2,
    OcPast   = 2'd3
  } outcome_e;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic        [23:0] a_radius;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
    logic        [23:0] b_radius;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] contact_time;
    logic [31:0] contact_distance;
    logic [1:0]  outcome;
  } res_t;

endpackage

// ===== design/scte_mul.sv =====
// Pipelined unsigned multiplier, one 32 by 32 partial product per stage, with sideband.
module scte_mul #(
  parameter int unsigned WA = 33,
  parameter int unsigned WB = 33,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [WA-1:0]    a_i,
  input  logic [WB-1:0]    b_i,
  input  logic [SW-1:0]    side_i,
  output logic             out_valid_o,
  output logic [WA+WB-1:0] p_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned CW = 32;
  localparam int unsigned NA = (WA + CW - 1) / CW;
  localparam int unsigned NB = (WB + CW - 1) / CW;
  localparam int unsigned NP = NA * NB;
  localparam int unsigned PW = CW * (NA + NB);

  logic [NA*CW-1:0] a_d   [NP];
  logic [NB*CW-1:0] b_d   [NP];
  logic [PW-1:0]    acc_d [NP];
  logic [SW-1:0]    s_d   [NP];
  logic             v_d   [NP];
  logic [NA*CW-1:0] a_q   [NP];
  logic [NB*CW-1:0] b_q   [NP];
  logic [PW-1:0]    acc_q [NP];
  logic [SW-1:0]    s_q   [NP];
  logic             v_q   [NP];

  for (genvar k = 0; k < NP; k++) begin : g_stage
    localparam int unsigned IA = k / NB;
    localparam int unsigned IB = k % NB;
    logic [2*CW-1:0] pp;
    logic [PW-1:0]   acc_in;
    if (k == 0) begin : g_first
      assign a_d[k]  = (NA*CW)'(a_i);
      assign b_d[k]  = (NB*CW)'(b_i);
      assign s_d[k]  = side_i;
      assign v_d[k]  = in_valid_i;
      assign acc_in  = '0;
    end else begin : g_next
      assign a_d[k]  = a_q[k-1];
      assign b_d[k]  = b_q[k-1];
      assign s_d[k]  = s_q[k-1];
      assign v_d[k]  = v_q[k-1];
      assign acc_in  = acc_q[k-1];
    end
    assign pp       = a_d[k][IA*CW +: CW] * b_d[k][IB*CW +: CW];
    assign acc_d[k] = acc_in + (PW'(pp) << ((IA + IB) * CW));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NP; k++) v_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NP; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NP; k++) begin
      a_q[k]   <= a_d[k];
      b_q[k]   <= b_d[k];
      s_q[k]   <= s_d[k];
      acc_q[k] <= acc_d[k];
    end
  end

  assign out_valid_o = v_q[NP-1];
  assign p_o         = acc_q[NP-1][WA+WB-1:0];
  assign side_o      = s_q[NP-1];

endmodule

// ===== design/scte_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband.
module scte_sqrt #(
  parameter int unsigned W  = 132,
  parameter int unsigned SW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [W-1:0]   x_i,
  input  logic [SW-1:0]  side_i,
  output logic           out_valid_o,
  output logic [W/2-1:0] root_o,
  output logic [SW-1:0]  side_o
);

  localparam int unsigned NQ = W / 2;
  localparam int unsigned RW = NQ + 2;

  logic [W-1:0]  x_d    [NQ];
  logic [RW-1:0] rem_d  [NQ];
  logic [NQ-1:0] root_d [NQ];
  logic [SW-1:0] s_d    [NQ];
  logic          v_d    [NQ];
  logic [W-1:0]  x_q    [NQ];
  logic [RW-1:0] rem_q  [NQ];
  logic [NQ-1:0] root_q [NQ];
  logic [SW-1:0] s_q    [NQ];
  logic          v_q    [NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_stage
    logic [W-1:0]  x_in;
    logic [RW-1:0] rem_in;
    logic [NQ-1:0] root_in;
    logic [RW-1:0] rt;
    logic [RW-1:0] tt;
    logic          ge;
    if (k == 0) begin : g_first
      assign x_in    = x_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_d[k]  = side_i;
      assign v_d[k]  = in_valid_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_d[k]  = s_q[k-1];
      assign v_d[k]  = v_q[k-1];
    end
    // bring down the next pair of radicand bits, try the digit one
    assign rt        = {rem_in[RW-3:0], x_in[W-1 -: 2]};
    assign tt        = {root_in, 2'b01};
    assign ge        = rt >= tt;
    assign rem_d[k]  = ge ? rt - tt : rt;
    assign root_d[k] = {root_in[NQ-2:0], ge};
    assign x_d[k]    = x_in << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NQ; k++) v_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NQ; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NQ; k++) begin
      x_q[k]    <= x_d[k];
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      s_q[k]    <= s_d[k];
    end
  end

  assign out_valid_o = v_q[NQ-1];
  assign root_o      = root_q[NQ-1];
  assign side_o      = s_q[NQ-1];

endmodule

// ===== design/swept_circle_contact_time.sv =====
// Top level of the swept circle contact time block: full pipeline from request to result.
//
// Usage:
//   Raise start with a request on req_i; the request is taken at any clock edge
//   where start is high and busy is low. busy stays low, so a new request may
//   be issued in every cycle.
//   Each result appears on res_o for exactly one cycle with done_o high,
//   in request order. The receiver cannot stall the pipeline and none is
//   needed: every stage advances each cycle and valid bits travel with the
//   data. Throughput is one request per cycle. The longest parts of the
//   pipeline are the two square root pipelines (66 stages each, one root
//   bit per stage), the 32 stage restoring divider for the time, and the
//   9 stage 66 by 66 bit multipliers.
//   The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i,
//   cfg_data_i) writes radius_scale (index 0) and still_threshold (index 1);
//   it is always ready and should only be used while no request is in flight.
//   Reset clears all valid bits and returns both registers to their defaults
//   (radius_scale one, still_threshold 7); requests in flight are dropped without a result.
module swept_circle_contact_time (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  scte_pkg::req_t      req_i,
  output logic                done_o,
  output scte_pkg::res_t      res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  typedef struct packed {
    logic        rx_n;
    logic        ry_n;
    logic        vx_n;
    logic        vy_n;
    logic [32:0] rx_m;
    logic [32:0] ry_m;
    logic [32:0] vx_m;
    logic [32:0] vy_m;
  } geo_t;

  typedef struct packed {
    logic        still;
    logic        still_hit;
    logic        noreal;
    logic        past;
    logic [31:0] still_dist;
  } ctl_t;

  typedef struct packed {
    logic [65:0]        sp;
    logic [65:0]        d2;
    logic signed [66:0] h;
    logic               still;
    logic               cneg;
    geo_t               geo;
  } seg2_t;

  typedef struct packed {
    logic               noreal;
    logic               still;
    logic               still_hit;
    logic signed [66:0] h;
    logic [65:0]        sp;
    geo_t               geo;
  } seg3_t;

  typedef struct packed {
    logic [66:0] rem;
    logic [31:0] nlo;
    logic [31:0] q;
    logic        sat;
    logic [65:0] a;
    ctl_t        ctl;
    geo_t        geo;
  } dv_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [31:0] t;
    geo_t        geo;
  } tail_geo_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [31:0] t;
  } tail_t;

  function automatic logic [32:0] mag33(input logic [32:0] d);
    return d[32] ? -d : d;
  endfunction

  // configuration registers
  logic [15:0] scale_q;
  logic [31:0] thr_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= scte_pkg::RadiusScaleRst;
      thr_q   <= scte_pkg::StillThrRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        scte_pkg::CfgRadiusScale: scale_q <= cfg_data_i[15:0];
        scte_pkg::CfgStillThr:    thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: relative geometry and contact radius
  logic [32:0] drx, dry, dvx, dvy;
  logic [24:0] rsum;
  logic [40:0] rprod;
  geo_t        geo1_d, geo1_q;
  logic [28:0] rad1_q;
  logic        v1_q;

  assign drx   = 33'(req_i.b_pos_x) - 33'(req_i.a_pos_x);
  assign dry   = 33'(req_i.b_pos_y) - 33'(req_i.a_pos_y);
  assign dvx   = 33'(req_i.b_vel_x) - 33'(req_i.a_vel_x);
  assign dvy   = 33'(req_i.b_vel_y) - 33'(req_i.a_vel_y);
  assign rsum  = 25'(req_i.a_radius) + 25'(req_i.b_radius);
  assign rprod = 41'(rsum) * 41'(scale_q);

  always_comb begin
    geo1_d.rx_n = drx[32];
    geo1_d.ry_n = dry[32];
    geo1_d.vx_n = dvx[32];
    geo1_d.vy_n = dvy[32];
    geo1_d.rx_m = mag33(drx);
    geo1_d.ry_m = mag33(dry);
    geo1_d.vx_m = mag33(dvx);
    geo1_d.vy_m = mag33(dvy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    geo1_q <= geo1_d;
    rad1_q <= rprod[40:12];
  end

  // squares and dot products of the relative vectors, and the squared contact radius
  logic        g1_v;
  geo_t        g1_geo;
  logic [65:0] p_vx, p_vy, p_rx, p_ry, p_hx, p_hy, p_rr;

  scte_mul #(.WA(33), .WB(33), .SW($bits(geo_t))) u_mul_vx (
    .clk_i, .rst_ni, .in_valid_i(v1_q), .a_i(geo1_q.vx_m), .b_i(geo1_q.vx_m),
    .side_i(geo1_q), .out_valid_o(g1_v), .p_o(p_vx), .side_o(g1_geo)
  );
  scte_mul #(.WA(33), .WB(33), .SW(1)) u_mul_vy (
    .clk_i, .rst_ni, .in_valid_i(v1_q), .a_i(geo1_q.vy_m), .b_i(geo1_q.vy_m),
    .side_i(1'b0), .out_valid_o(), .p_o(p_vy), .side_o()
  );
  scte_mul #(.WA(33), .WB(33), .SW(1)) u_mul_rx (
    .clk_i, .rst_ni, .in_valid_i(v1_q), .a_i(geo1_q.rx_m), .b_i(geo1_q.rx_m),
    .side_i(1'b0), .out_valid_o(), .p_o(p_rx), .side_o()
  );
  scte_mul #(.WA(33), .WB(33), .SW(1)) u_mul_ry (
    .clk_i, .rst_ni, .in_valid_i(v1_q), .a_i(geo1_q.ry_m), .b_i(geo1_q.ry_m),
    .side_i(1'b0), .out_valid_o(), .p_o(p_ry), .side_o()
  );
  scte_mul #(.WA(33), .WB(33), .SW(1)) u_mul_hx (
    .clk_i, .rst_ni, .in_valid_i(v1_q), .a_i(geo1_q.rx_m), .b_i(geo1_q.vx_m),
    .side_i(1'b0), .out_valid_o(), .p_o(p_hx), .side_o()
  );
  scte_mul #(.WA(33), .WB(33), .SW(1)) u_mul_hy (
    .clk_i, .rst_ni, .in_valid_i(v1_q), .a_i(geo1_q.ry_m), .b_i(geo1_q.vy_m),
    .side_i(1'b0), .out_valid_o(), .p_o(p_hy), .side_o()
  );
  scte_mul #(.WA(33), .WB(33), .SW(1)) u_mul_rr (
    .clk_i, .rst_ni, .in_valid_i(v1_q), .a_i(33'(rad1_q)), .b_i(33'(rad1_q)),
    .side_i(1'b0), .out_valid_o(), .p_o(p_rr), .side_o()
  );

  // stage 3: quadratic coefficients and the still test
  logic [65:0]        sp3_d, d2_3_d, sp3_q, d2_3_q;
  logic signed [66:0] h3_d, c3_d, h3_q, c3_q;
  logic               still3_d, still3_q, v3_q;
  geo_t               geo3_q;

  always_comb begin
    sp3_d    = p_vx + p_vy;
    d2_3_d   = p_rx + p_ry;
    h3_d     = ((g1_geo.rx_n ^ g1_geo.vx_n) ? -67'(p_hx) : 67'(p_hx))
             + ((g1_geo.ry_n ^ g1_geo.vy_n) ? -67'(p_hy) : 67'(p_hy));
    c3_d     = 67'(d2_3_d) - 67'(p_rr);
    still3_d = (sp3_d == '0) || (sp3_d < 66'({thr_q, 16'd0}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= g1_v;
  end

  always_ff @(posedge clk_i) begin
    sp3_q    <= sp3_d;
    d2_3_q   <= d2_3_d;
    h3_q     <= h3_d;
    c3_q     <= c3_d;
    still3_q <= still3_d;
    geo3_q   <= g1_geo;
  end

  // stage 4: magnitudes for the discriminant products
  logic [66:0] hneg4, cneg4;
  logic [65:0] hmag4_q, cmag4_q;
  seg2_t       seg2_d, seg2_q;
  logic        v4_q;

  assign hneg4 = -h3_q;
  assign cneg4 = -c3_q;

  always_comb begin
    seg2_d.sp    = sp3_q;
    seg2_d.d2    = d2_3_q;
    seg2_d.h     = h3_q;
    seg2_d.still = still3_q;
    seg2_d.cneg  = c3_q[66];
    seg2_d.geo   = geo3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    hmag4_q <= h3_q[66] ? hneg4[65:0] : h3_q[65:0];
    cmag4_q <= c3_q[66] ? cneg4[65:0] : c3_q[65:0];
    seg2_q  <= seg2_d;
  end

  logic         g2_v;
  seg2_t        g2_seg;
  logic [131:0] p_hh, p_ac;

  scte_mul #(.WA(66), .WB(66), .SW($bits(seg2_t))) u_mul_hh (
    .clk_i, .rst_ni, .in_valid_i(v4_q), .a_i(hmag4_q), .b_i(hmag4_q),
    .side_i(seg2_q), .out_valid_o(g2_v), .p_o(p_hh), .side_o(g2_seg)
  );
  scte_mul #(.WA(66), .WB(66), .SW(1)) u_mul_ac (
    .clk_i, .rst_ni, .in_valid_i(v4_q), .a_i(seg2_q.sp), .b_i(cmag4_q),
    .side_i(1'b0), .out_valid_o(), .p_o(p_ac), .side_o()
  );

  // stage 5: discriminant, and pick the radicand for the shared root
  logic [132:0] dsum5, ddif5;
  logic         noreal5;
  logic [131:0] sq5_d, sq5_q;
  seg3_t        seg3_d, seg3_q;
  logic         v5_q;

  always_comb begin
    dsum5   = 133'(p_hh) + 133'(p_ac);
    ddif5   = 133'(p_hh) - 133'(p_ac);
    noreal5 = !g2_seg.cneg && (p_hh < p_ac);
    if (g2_seg.still) begin
      sq5_d = 132'(g2_seg.d2);
    end else if (noreal5) begin
      sq5_d = '0;
    end else if (g2_seg.cneg) begin
      sq5_d = dsum5[131:0];
    end else begin
      sq5_d = ddif5[131:0];
    end
    seg3_d.noreal    = noreal5;
    seg3_d.still     = g2_seg.still;
    seg3_d.still_hit = g2_seg.cneg;
    seg3_d.h         = g2_seg.h;
    seg3_d.sp        = g2_seg.sp;
    seg3_d.geo       = g2_seg.geo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= g2_v;
  end

  always_ff @(posedge clk_i) begin
    sq5_q  <= sq5_d;
    seg3_q <= seg3_d;
  end

  logic        r1_v;
  logic [65:0] r1_root;
  seg3_t       r1_seg;

  scte_sqrt #(.W(132), .SW($bits(seg3_t))) u_sqrt_disc (
    .clk_i, .rst_ni, .in_valid_i(v5_q), .x_i(sq5_q), .side_i(seg3_q),
    .out_valid_o(r1_v), .root_o(r1_root), .side_o(r1_seg)
  );

  // stage 6: root numerator, earlier non-negative root first
  logic [68:0] nh6, n1_6, n2_6;
  logic [66:0] num6_q;
  logic [65:0] sp6_q;
  ctl_t        ctl6_d, ctl6_q;
  geo_t        geo6_q;
  logic        v6_q;

  always_comb begin
    nh6                = -{{2{r1_seg.h[66]}}, r1_seg.h};
    n1_6               = nh6 - {3'b000, r1_root};
    n2_6               = nh6 + {3'b000, r1_root};
    ctl6_d.still       = r1_seg.still;
    ctl6_d.still_hit   = r1_seg.still_hit;
    ctl6_d.noreal      = r1_seg.noreal;
    ctl6_d.past        = n1_6[68] && n2_6[68];
    ctl6_d.still_dist  = (r1_root[65:32] != '0) ? '1 : r1_root[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= r1_v;
  end

  always_ff @(posedge clk_i) begin
    num6_q <= n1_6[68] ? n2_6[66:0] : n1_6[66:0];
    sp6_q  <= r1_seg.sp;
    ctl6_q <= ctl6_d;
    geo6_q <= r1_seg.geo;
  end

  // stage 7 and the divider: time = numerator * 2^16 / a, one quotient bit per stage
  dv_t  dv_d [33];
  dv_t  dv_q [33];
  logic dvv_q [33];

  always_comb begin
    dv_d[0].rem = 67'(num6_q[66:16]);
    dv_d[0].nlo = {num6_q[15:0], 16'd0};
    dv_d[0].q   = '0;
    // quotient cannot fit in 32 bits: saturate
    dv_d[0].sat = 82'(num6_q) >= {sp6_q, 16'd0};
    dv_d[0].a   = sp6_q;
    dv_d[0].ctl = ctl6_q;
    dv_d[0].geo = geo6_q;
  end

  for (genvar k = 0; k < 32; k++) begin : g_div
    logic [66:0] rt;
    logic        ge;
    assign rt = {dv_q[k].rem[65:0], dv_q[k].nlo[31]};
    assign ge = rt >= {1'b0, dv_q[k].a};
    always_comb begin
      dv_d[k+1]     = dv_q[k];
      dv_d[k+1].rem = ge ? rt - {1'b0, dv_q[k].a} : rt;
      dv_d[k+1].q   = {dv_q[k].q[30:0], ge};
      dv_d[k+1].nlo = {dv_q[k].nlo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 33; k++) dvv_q[k] <= 1'b0;
    end else begin
      dvv_q[0] <= v6_q;
      for (int k = 1; k < 33; k++) dvv_q[k] <= dvv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 33; k++) dv_q[k] <= dv_d[k];
  end

  // velocity times the reported time
  logic [31:0] t8;
  tail_geo_t   tg8;
  logic        g3_v;
  tail_geo_t   g3_side;
  logic [64:0] p_tx, p_ty;

  assign t8 = dv_q[32].sat ? '1 : dv_q[32].q;

  always_comb begin
    tg8.ctl = dv_q[32].ctl;
    tg8.t   = t8;
    tg8.geo = dv_q[32].geo;
  end

  scte_mul #(.WA(33), .WB(32), .SW($bits(tail_geo_t))) u_mul_tx (
    .clk_i, .rst_ni, .in_valid_i(dvv_q[32]), .a_i(dv_q[32].geo.vx_m), .b_i(t8),
    .side_i(tg8), .out_valid_o(g3_v), .p_o(p_tx), .side_o(g3_side)
  );
  scte_mul #(.WA(33), .WB(32), .SW(1)) u_mul_ty (
    .clk_i, .rst_ni, .in_valid_i(dvv_q[32]), .a_i(dv_q[32].geo.vy_m), .b_i(t8),
    .side_i(1'b0), .out_valid_o(), .p_o(p_ty), .side_o()
  );

  // stage 9: relative position at the contact time
  logic signed [66:0] px9_q, py9_q;
  tail_t              tail9_d, tail9_q;
  logic               v9_q;
  logic [48:0]        ax9, ay9;

  assign ax9 = {g3_side.geo.rx_m, 16'd0};
  assign ay9 = {g3_side.geo.ry_m, 16'd0};

  always_comb begin
    tail9_d.ctl = g3_side.ctl;
    tail9_d.t   = g3_side.t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else         v9_q <= g3_v;
  end

  always_ff @(posedge clk_i) begin
    px9_q   <= (g3_side.geo.rx_n ? -67'(ax9) : 67'(ax9))
             + (g3_side.geo.vx_n ? -67'(p_tx) : 67'(p_tx));
    py9_q   <= (g3_side.geo.ry_n ? -67'(ay9) : 67'(ay9))
             + (g3_side.geo.vy_n ? -67'(p_ty) : 67'(p_ty));
    tail9_q <= tail9_d;
  end

  // stage 10: magnitudes
  logic [66:0] pxn10, pyn10;
  logic [65:0] pxm10_q, pym10_q;
  tail_t       tail10_q;
  logic        v10_q;

  assign pxn10 = -px9_q;
  assign pyn10 = -py9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v10_q <= 1'b0;
    else         v10_q <= v9_q;
  end

  always_ff @(posedge clk_i) begin
    pxm10_q  <= px9_q[66] ? pxn10[65:0] : px9_q[65:0];
    pym10_q  <= py9_q[66] ? pyn10[65:0] : py9_q[65:0];
    tail10_q <= tail9_q;
  end

  logic         g4_v;
  tail_t        g4_side;
  logic [131:0] p_xx, p_yy;

  scte_mul #(.WA(66), .WB(66), .SW($bits(tail_t))) u_mul_xx (
    .clk_i, .rst_ni, .in_valid_i(v10_q), .a_i(pxm10_q), .b_i(pxm10_q),
    .side_i(tail10_q), .out_valid_o(g4_v), .p_o(p_xx), .side_o(g4_side)
  );
  scte_mul #(.WA(66), .WB(66), .SW(1)) u_mul_yy (
    .clk_i, .rst_ni, .in_valid_i(v10_q), .a_i(pym10_q), .b_i(pym10_q),
    .side_i(1'b0), .out_valid_o(), .p_o(p_yy), .side_o()
  );

  // stage 11: squared distance
  logic [131:0] dd11_q;
  tail_t        tail11_q;
  logic         v11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v11_q <= 1'b0;
    else         v11_q <= g4_v;
  end

  always_ff @(posedge clk_i) begin
    dd11_q   <= p_xx + p_yy;
    tail11_q <= g4_side;
  end

  logic        r2_v;
  logic [65:0] r2_root;
  tail_t       r2_side;

  scte_sqrt #(.W(132), .SW($bits(tail_t))) u_sqrt_dist (
    .clk_i, .rst_ni, .in_valid_i(v11_q), .x_i(dd11_q), .side_i(tail11_q),
    .out_valid_o(r2_v), .root_o(r2_root), .side_o(r2_side)
  );

  // result register: still case first, then no root, then past only
  scte_pkg::res_t res_d, res_q;
  logic           done_q;
  logic [31:0]    dist_mv;

  assign dist_mv = (r2_root[65:48] != '0) ? '1 : r2_root[47:16];

  always_comb begin
    res_d.hit              = 1'b1;
    res_d.contact_time     = r2_side.t;
    res_d.contact_distance = dist_mv;
    res_d.outcome          = scte_pkg::OcMoving;
    if (r2_side.ctl.still) begin
      res_d.hit              = r2_side.ctl.still_hit;
      res_d.contact_time     = '0;
      res_d.contact_distance = r2_side.ctl.still_dist;
      res_d.outcome          = scte_pkg::OcStill;
    end else if (r2_side.ctl.noreal) begin
      res_d.hit              = 1'b0;
      res_d.contact_time     = '0;
      res_d.contact_distance = '0;
      res_d.outcome          = scte_pkg::OcNoRoot;
    end else if (r2_side.ctl.past) begin
      res_d.hit              = 1'b0;
      res_d.contact_time     = '0;
      res_d.contact_distance = '0;
      res_d.outcome          = scte_pkg::OcPast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= r2_v;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
